// ===== rtl/mixed_speed_temp_separator_defines.svh =====
// Assertion macros for the mixed speed and temperature separator.
// Included by the port checker; no other dependencies.
`ifndef MIXED_SPEED_TEMP_SEPARATOR_DEFINES_SVH
`define MIXED_SPEED_TEMP_SEPARATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mst assertion failed");

`endif

// ===== rtl/mst_pkg.sv =====
// Shared types and constants for the mixed speed and temperature separator.
// Used by the controller, the datapath and the top level; no dependencies.
package mst_pkg;

    localparam int AVERAGE_DEPTH_DEF = 8;
    localparam int SAMPLE_BITS_DEF   = 12;

    localparam int SAMPLE_W   = 12;
    localparam int TICK_W     = 16;
    localparam int CNT_W      = 32;
    localparam int TEMP_W     = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 3;

    localparam logic [TICK_W-1:0] TICK_RESET      = 16'd100;
    localparam logic [TEMP_W-1:0] THRESHOLD_RESET = 12'd200;
    localparam logic [CNT_W-1:0]  TIMEOUT_RESET   = 32'd2000000;
    localparam logic [CNT_W-1:0]  WINDOW_RESET    = 32'd1000000;
    localparam logic [TEMP_W-1:0] INIT_TEMP_RESET = 12'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TICK_US        = 3'd0,
        CFG_LOW_THRESHOLD  = 3'd1,
        CFG_TIMEOUT_US     = 3'd2,
        CFG_TEMP_WINDOW_US = 3'd3,
        CFG_INITIAL_TEMP   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic sum_step;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic ended;
        logic sum_last;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/mixed_speed_temp_separator.sv =====
// A sample that does not end a period goes from acceptance straight to the finish step,
// which writes the registered result; one that ends a period first passes through the ring
// sum and the divider. The controller takes a new sample only in its idle state, so it cannot
// take the next sample before the previous one has been finished; the finish step also
// stalls while the previous result word still waits downstream.
module mixed_speed_temp_separator #(
    parameter int AVERAGE_DEPTH = mst_pkg::AVERAGE_DEPTH_DEF,
    parameter int SAMPLE_BITS   = mst_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port: index 0 tick_us, 1 low_threshold, 2 timeout_us,
    // 3 temp_window_us, 4 initial_temperature.
    input  logic                              cfg_wr_en,
    input  logic [mst_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Sample stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mst_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] sample, rest zero
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mst_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] avg_period_us,
                                                         // [43:32] temperature_raw
    output logic [mst_pkg::M_TUSER_W-1:0]     m_tuser    // [0] period_updated,
                                                         // [1] temperature_updated,
                                                         // [2] timed_out
);
    import mst_pkg::*;

    // Reset (rst_n, asynchronous, active low) restores register defaults and clears state.

    // The controller and the datapath talk only through these two structs.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller accepts a word only in its idle state. A finished result
    // sits in the datapath's output register, so the next sample can be taken
    // while the previous word still waits downstream; the finish step stalls
    // only when that register is still occupied.
    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the edge tracker, the period ring,
    // the accumulator, the divider and the temperature peak logic. The speed
    // update happens when the word is accepted; the timeout check and the
    // temperature update happen in the finish step, after any new average.
    mst_dp #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/mst_ctrl.sv =====
// Sequencing state machine for the separator: accept, ring sum, divide, finish.
// Depends on mst_pkg for the state type and the command and status structs.
module mst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mst_pkg::dp_status_t status,
    output mst_pkg::dp_cmd_t    cmd
);
    import mst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.ended ? ST_SUM : ST_FINISH;
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mst_dp.sv =====
// Datapath of the separator: configuration, edge tracking, period ring memory,
// ring accumulator, restoring divider, temperature peak logic and output word.
// Depends on mst_pkg; driven by the commands of mst_ctrl.
module mst_dp #(
    parameter int AVERAGE_DEPTH = mst_pkg::AVERAGE_DEPTH_DEF,
    parameter int SAMPLE_BITS   = mst_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mst_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mst_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [mst_pkg::SAMPLE_W-1:0]      sample,
    input  mst_pkg::dp_cmd_t                  cmd,
    output mst_pkg::dp_status_t               status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mst_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [mst_pkg::M_TUSER_W-1:0]     m_tuser
);
    import mst_pkg::*;

    localparam int FW  = $clog2(AVERAGE_DEPTH + 1);
    localparam int IW  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SW  = CNT_W + $clog2(AVERAGE_DEPTH);
    localparam int DCW = $clog2(SW);
    localparam logic [SAMPLE_W-1:0] SampleMask = (SAMPLE_BITS >= SAMPLE_W) ?
        {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [TICK_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W + 1)'(b);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Configuration registers.
    logic [TICK_W-1:0] tick_reg;
    logic [TEMP_W-1:0] thr_reg;
    logic [CNT_W-1:0]  timeout_reg;
    logic [CNT_W-1:0]  window_len_reg;
    logic [TEMP_W-1:0] init_temp_reg;

    // Speed tracking state.
    logic              low_seen_reg;
    logic              started_reg;
    logic              second_low_reg;
    logic [CNT_W-1:0]  period_reg;
    logic [IW-1:0]     ring_idx_reg;
    logic [FW-1:0]     fill_reg;
    logic [CNT_W-1:0]  avg_reg;
    logic              ended_reg;

    // Temperature state.
    logic [TEMP_W-1:0] peak_reg;
    logic [TEMP_W-1:0] latched_reg;
    logic [CNT_W-1:0]  window_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // Ring memory and accumulator.
    logic [CNT_W-1:0]  ring_mem [AVERAGE_DEPTH];
    logic [CNT_W-1:0]  ring_rd_reg;
    logic              rd_pend_reg;
    logic [FW-1:0]     sum_cnt_reg;
    logic [SW-1:0]     sum_reg;

    // Divider.
    logic [SW-1:0]     quo_reg;
    logic [FW-1:0]     rem_reg;
    logic [DCW-1:0]    div_cnt_reg;

    // Output register.
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    // Edge tracking for the incoming sample.
    logic [SAMPLE_W-1:0] s_in;
    logic                low;
    logic                started_next;
    logic                ended;
    logic [CNT_W-1:0]    period_next;
    logic [IW-1:0]       rd_addr;
    logic                rd_issue;
    logic [SW-1:0]       sum_acc;
    logic [FW:0]         div_trial;
    logic                div_ge;
    logic [FW:0]         div_diff;
    logic [SW-1:0]       quo_next;
    logic [FW-1:0]       rem_next;
    logic                tout;
    logic [CNT_W-1:0]    avg_eff;
    logic [TEMP_W-1:0]   peak_max;
    logic                tupd;
    logic [TEMP_W-1:0]   latched_next;

    always_comb
    begin
        s_in         = sample & SampleMask;
        low          = s_in < thr_reg;
        started_next = started_reg | (!low & low_seen_reg);
        ended        = low & started_next;
        period_next  = sat_add((low && !low_seen_reg) ? '0 : period_reg, tick_reg);

        rd_addr      = sum_cnt_reg[IW-1:0];
        rd_issue     = sum_cnt_reg < fill_reg;
        sum_acc      = sum_reg + (rd_pend_reg ? SW'(ring_rd_reg) : '0);

        div_trial    = {rem_reg, quo_reg[SW-1]};
        div_ge       = div_trial >= {1'b0, fill_reg};
        div_diff     = div_trial - {1'b0, fill_reg};
        rem_next     = div_ge ? div_diff[FW-1:0] : div_trial[FW-1:0];
        quo_next     = {quo_reg[SW-2:0], div_ge};

        tout         = period_reg >= timeout_reg;
        avg_eff      = tout ? '0 : avg_reg;
        peak_max     = (sample_reg > peak_reg) ? sample_reg : peak_reg;
        tupd         = (peak_max > thr_reg) && (window_reg >= window_len_reg) &&
                       (avg_eff != '0);
        latched_next = tupd ? peak_max : latched_reg;

        status.ended    = ended;
        status.sum_last = sum_cnt_reg == fill_reg;
        status.div_last = div_cnt_reg == DCW'(SW - 1);
        status.out_free = !m_tvalid_reg || m_tready;
    end

    // Period ring: one write per finished measurement, one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && ended)
        begin
            ring_mem[ring_idx_reg] <= period_next;
        end
        ring_rd_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= TICK_RESET;
            thr_reg        <= THRESHOLD_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            window_len_reg <= WINDOW_RESET;
            init_temp_reg  <= INIT_TEMP_RESET;
            low_seen_reg   <= 1'b0;
            started_reg    <= 1'b0;
            second_low_reg <= 1'b0;
            period_reg     <= '0;
            ring_idx_reg   <= '0;
            fill_reg       <= '0;
            avg_reg        <= '0;
            ended_reg      <= 1'b0;
            peak_reg       <= INIT_TEMP_RESET;
            latched_reg    <= INIT_TEMP_RESET;
            window_reg     <= '0;
            sample_reg     <= '0;
            rd_pend_reg    <= 1'b0;
            sum_cnt_reg    <= '0;
            sum_reg        <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_TICK_US:        tick_reg       <= cfg_wdata[TICK_W-1:0];
                    CFG_LOW_THRESHOLD:  thr_reg        <= cfg_wdata[TEMP_W-1:0];
                    CFG_TIMEOUT_US:     timeout_reg    <= cfg_wdata;
                    CFG_TEMP_WINDOW_US: window_len_reg <= cfg_wdata;
                    CFG_INITIAL_TEMP:
                    begin
                        init_temp_reg <= cfg_wdata[TEMP_W-1:0];
                        peak_reg      <= cfg_wdata[TEMP_W-1:0];
                        latched_reg   <= cfg_wdata[TEMP_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.accept)
            begin
                sample_reg  <= s_in;
                ended_reg   <= ended;
                sum_cnt_reg <= '0;
                sum_reg     <= '0;
                rd_pend_reg <= 1'b0;
                if (ended)
                begin
                    low_seen_reg   <= 1'b0;
                    started_reg    <= 1'b0;
                    second_low_reg <= 1'b0;
                    period_reg     <= '0;
                    fill_reg       <= (fill_reg == FW'(AVERAGE_DEPTH)) ?
                                      fill_reg : fill_reg + 1'b1;
                    ring_idx_reg   <= (ring_idx_reg == IW'(AVERAGE_DEPTH - 1)) ?
                                      '0 : ring_idx_reg + 1'b1;
                end
                else
                begin
                    low_seen_reg   <= low_seen_reg | low;
                    started_reg    <= started_next;
                    second_low_reg <= second_low_reg | (low & started_next);
                    period_reg     <= period_next;
                end
            end

            if (cmd.sum_step)
            begin
                sum_reg     <= sum_acc;
                rd_pend_reg <= rd_issue;
                sum_cnt_reg <= sum_cnt_reg + 1'b1;
                if (status.sum_last)
                begin
                    quo_reg     <= sum_acc;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
            end

            if (cmd.div_step)
            begin
                quo_reg     <= quo_next;
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (status.div_last)
                begin
                    avg_reg <= quo_next[CNT_W-1:0];
                end
            end

            if (cmd.finish)
            begin
                if (tout)
                begin
                    low_seen_reg   <= 1'b0;
                    started_reg    <= 1'b0;
                    second_low_reg <= 1'b0;
                    period_reg     <= '0;
                    ring_idx_reg   <= '0;
                    fill_reg       <= '0;
                    avg_reg        <= '0;
                end
                peak_reg     <= tupd ? '0 : peak_max;
                latched_reg  <= latched_next;
                window_reg   <= sat_add(tupd ? '0 : window_reg, tick_reg);
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{(M_TDATA_W - CNT_W - TEMP_W){1'b0}}, latched_next, avg_eff};
                m_tuser_reg  <= {tout, tupd, ended_reg};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/mst_checker.sv =====
// Port-level checker for the separator, bound to the top level.
// Depends on mst_pkg and the assertion macros in the defines header.
`include "mixed_speed_temp_separator_defines.svh"

module mst_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mst_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [mst_pkg::M_TUSER_W-1:0]     m_tuser
);
    import mst_pkg::*;

    logic [1:0] outstanding_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Words accepted but not yet delivered: at most one in work and one waiting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    `MST_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MST_ASSERT_IMPLY(a_no_spurious, clk, rst_n, m_tvalid, outstanding_reg != 2'd0)
    `MST_ASSERT_IMPLY(a_bounded, clk, rst_n, 1'b1, outstanding_reg != 2'd3)
    `MST_ASSERT_IMPLY(a_timeout_zero, clk, rst_n, m_tvalid && m_tuser[2], m_tdata[31:0] == 32'd0)
    `MST_ASSERT_IMPLY(a_latch_moving, clk, rst_n, m_tvalid && m_tuser[1], m_tdata[31:0] != 32'd0)

endmodule

bind mixed_speed_temp_separator mst_checker u_mst_checker (.*);
